### hw/rtl/dtbe_pkg.sv
// ----------------------------------------------------------------------------
// dtbe_pkg
// shared constants and types for the bilinear terrain elevation block
// ----------------------------------------------------------------------------
`default_nettype none
package dtbe_pkg;
  localparam int NUM_TILES   = 4;
  localparam int GRID_POINTS = 1201;
  localparam int FRAC_BITS   = 20;
  localparam int SLOT_W      = 2;
  localparam int TILE_WORDS  = GRID_POINTS * GRID_POINTS;
  localparam int STORE_WORDS = NUM_TILES * TILE_WORDS;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int IDX_W       = 21;
  localparam int GIDX_W      = $clog2(GRID_POINTS);
  localparam int POS_W       = FRAC_BITS + GIDX_W + 1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BIND  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;
endpackage
`default_nettype wire

### hw/rtl/dtbe_ram.sv
// ----------------------------------------------------------------------------
// dtbe_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module dtbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/dem_tile_bilinear_elevation_top.sv
// ----------------------------------------------------------------------------
// dem_tile_bilinear_elevation_top
// terrain elevation lookup with bilinear interpolation over stored tiles
// ----------------------------------------------------------------------------
// usage: drive in_* and pulse start; a transaction is taken when start is high
// and busy is low. busy is tied low, so one transaction can enter every cycle.
// load transactions write one byte-swapped sample into all four copies of the
// corner memory; bind transactions set a tile slot key and valid mark.
// a query produces one result on out_* marked by out_valid; loads and binds
// produce no result. queries go through a seven stage pipeline: locate, tile
// match, clamp, address, ram read, horizontal blend, vertical blend and round.
// samples are held four times (one copy per interpolation corner) so all four
// corners are read in the same cycle.
// a load is seen by queries that enter in any later cycle.
// reset clears slot valid marks and keys and the pipeline valid bits; sample
// memory is not cleared. the receiver cannot stall, so nothing ever waits.
// ----------------------------------------------------------------------------
`default_nettype none
module dem_tile_bilinear_elevation_top
  import dtbe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_action,
  input  wire logic [1:0]          in_tile_slot,
  input  wire logic                in_slot_valid,
  input  wire logic signed [7:0]   in_tile_lat_deg,
  input  wire logic signed [8:0]   in_tile_lon_deg,
  input  wire logic [20:0]         in_sample_index,
  input  wire logic [15:0]         in_raw_sample,
  input  wire logic signed [27:0]  in_query_lat,
  input  wire logic signed [28:0]  in_query_lon,
  output logic                     out_valid,
  output logic signed [23:0]       out_elevation,
  output logic                     out_found
);
  localparam int GM1    = GRID_POINTS - 1;
  localparam int LAT_W  = 28 - FRAC_BITS;
  localparam int LON_W  = 29 - FRAC_BITS;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int SH     = 2 * FRAC_BITS - 8;
  localparam int H0_W   = 16 + WT_W + 1;
  localparam int H_W    = H0_W + WT_W + 1;
  localparam int BANK_A = $clog2(TILE_WORDS);
  localparam int TA_W   = $clog2(NUM_TILES) + BANK_A;
  localparam int WR_LAG = 4;

  assign busy = 1'b0;

  logic acc;
  assign acc = start;

  // slot table
  logic [NUM_TILES-1:0]       use_r;
  logic signed [7:0]          lat_key_r [NUM_TILES];
  logic signed [8:0]          lon_key_r [NUM_TILES];
  logic                       slot_ok;
  assign slot_ok = ({30'd0, in_tile_slot} < NUM_TILES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
      for (int k = 0; k < NUM_TILES; k++) begin
        lat_key_r[k] <= '0;
        lon_key_r[k] <= '0;
      end
    end else if (acc && action_t'(in_action) == ACT_BIND && slot_ok) begin
      use_r[in_tile_slot[$clog2(NUM_TILES)-1:0]]     <= in_slot_valid;
      lat_key_r[in_tile_slot[$clog2(NUM_TILES)-1:0]] <= in_tile_lat_deg;
      lon_key_r[in_tile_slot[$clog2(NUM_TILES)-1:0]] <= in_tile_lon_deg;
    end
  end

  // load path: the sample goes into all four corner copies
  logic [15:0] sw;
  logic        we;
  logic [TA_W-1:0] waddr;
  always_comb begin
    sw = {in_raw_sample[7:0], in_raw_sample[15:8]};
    if (sw == 16'h8000) begin
      sw = 16'h0000;
    end
    we = acc && action_t'(in_action) == ACT_LOAD && slot_ok &&
         ({11'd0, in_sample_index} < TILE_WORDS);
    waddr = TA_W'(in_tile_slot) * TA_W'(TILE_WORDS) + TA_W'(in_sample_index);
  end

  // writes pass through a four register delay line so earlier queries read the older store
  logic            wq_we_r   [WR_LAG];
  logic [TA_W-1:0] wq_addr_r [WR_LAG];
  logic [15:0]     wq_data_r [WR_LAG];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WR_LAG; k++) begin
        wq_we_r[k] <= 1'b0;
      end
    end else begin
      wq_we_r[0] <= we;
      for (int k = 1; k < WR_LAG; k++) begin
        wq_we_r[k] <= wq_we_r[k-1];
      end
    end
    wq_addr_r[0] <= waddr;
    wq_data_r[0] <= sw;
    for (int k = 1; k < WR_LAG; k++) begin
      wq_addr_r[k] <= wq_addr_r[k-1];
      wq_data_r[k] <= wq_data_r[k-1];
    end
  end

  // stage 1: locate
  logic                 v1_r;
  logic signed [LAT_W-1:0] tlat1_r;
  logic signed [LON_W-1:0] tlon1_r;
  logic [FRAC_BITS-1:0] fy1_r, fx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= acc && action_t'(in_action) == ACT_QUERY;
    tlat1_r <= in_query_lat[27:FRAC_BITS];
    tlon1_r <= in_query_lon[28:FRAC_BITS];
    fy1_r   <= in_query_lat[FRAC_BITS-1:0];
    fx1_r   <= in_query_lon[FRAC_BITS-1:0];
  end

  // stage 2: grid position and tile match
  logic [POS_W-1:0] py, px;
  logic [NUM_TILES-1:0] match;
  logic [$clog2(NUM_TILES)-1:0] hit;
  logic found;
  always_comb begin
    py = POS_W'(({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fy1_r})) * POS_W'(GM1);
    px = POS_W'(fx1_r) * POS_W'(GM1);
    for (int k = 0; k < NUM_TILES; k++) begin
      match[k] = use_r[k] && (LAT_W'(lat_key_r[k]) == tlat1_r) &&
                 (LON_W'(lon_key_r[k]) == tlon1_r);
    end
    hit = '0;
    for (int k = NUM_TILES - 1; k >= 0; k--) begin
      if (match[k]) hit = ($clog2(NUM_TILES))'(k);
    end
    found = |match;
  end

  logic v2_r, f2_r;
  logic [$clog2(NUM_TILES)-1:0] hit2_r;
  logic [POS_W-1:0] py2_r, px2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    f2_r   <= found;
    hit2_r <= hit;
    py2_r  <= py;
    px2_r  <= px;
  end

  // stage 3: clamp and weights
  logic [GIDX_W-1:0] row, col;
  logic [WT_W-1:0]   wy, wx;
  logic [TA_W-1:0]   a00;
  always_comb begin
    row = py2_r[POS_W-1:FRAC_BITS] > (POS_W-FRAC_BITS)'(GRID_POINTS - 2) ?
          GIDX_W'(GRID_POINTS - 2) : GIDX_W'(py2_r[POS_W-1:FRAC_BITS]);
    col = px2_r[POS_W-1:FRAC_BITS] > (POS_W-FRAC_BITS)'(GRID_POINTS - 2) ?
          GIDX_W'(GRID_POINTS - 2) : GIDX_W'(px2_r[POS_W-1:FRAC_BITS]);
    wy  = WT_W'(py2_r - {row, {FRAC_BITS{1'b0}}});
    wx  = WT_W'(px2_r - {col, {FRAC_BITS{1'b0}}});
  end

  logic v3_r, f3_r;
  logic [WT_W-1:0] wy3_r, wx3_r;
  logic [$clog2(NUM_TILES)-1:0] hit3_r;
  logic [GIDX_W-1:0] row3_r, col3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    f3_r <= f2_r; wy3_r <= wy; wx3_r <= wx;
    hit3_r <= hit2_r; row3_r <= row; col3_r <= col;
  end

  // stage 4: address add
  logic [TA_W-1:0] base4_r;
  logic v4_r, f4_r;
  logic [WT_W-1:0] wy4_r, wx4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    f4_r <= f3_r; wy4_r <= wy3_r; wx4_r <= wx3_r;
    base4_r <= TA_W'(hit3_r) * TA_W'(TILE_WORDS) +
               TA_W'(row3_r) * TA_W'(GRID_POINTS) + TA_W'(col3_r);
  end
  assign a00 = base4_r;

  // stage 5: corner reads
  logic [15:0] h00, h01, h10, h11;
  dtbe_ram #(.WIDTH(16), .DEPTH(NUM_TILES * TILE_WORDS)) u_r00 (
    .clk, .we(wq_we_r[WR_LAG-1]), .waddr(wq_addr_r[WR_LAG-1]),
    .wdata(wq_data_r[WR_LAG-1]), .raddr(a00), .rdata(h00));
  dtbe_ram #(.WIDTH(16), .DEPTH(NUM_TILES * TILE_WORDS)) u_r01 (
    .clk, .we(wq_we_r[WR_LAG-1]), .waddr(wq_addr_r[WR_LAG-1]),
    .wdata(wq_data_r[WR_LAG-1]), .raddr(a00 + TA_W'(1)), .rdata(h01));
  dtbe_ram #(.WIDTH(16), .DEPTH(NUM_TILES * TILE_WORDS)) u_r10 (
    .clk, .we(wq_we_r[WR_LAG-1]), .waddr(wq_addr_r[WR_LAG-1]),
    .wdata(wq_data_r[WR_LAG-1]), .raddr(a00 + TA_W'(GRID_POINTS)), .rdata(h10));
  dtbe_ram #(.WIDTH(16), .DEPTH(NUM_TILES * TILE_WORDS)) u_r11 (
    .clk, .we(wq_we_r[WR_LAG-1]), .waddr(wq_addr_r[WR_LAG-1]),
    .wdata(wq_data_r[WR_LAG-1]), .raddr(a00 + TA_W'(GRID_POINTS + 1)),
    .rdata(h11));

  logic v5_r, f5_r;
  logic [WT_W-1:0] wy5_r, wx5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    f5_r <= f4_r; wy5_r <= wy4_r; wx5_r <= wx4_r;
  end

  // stage 6: horizontal blend
  logic signed [WT_W:0] sx, sx1, sy, sy1;
  assign sx  = $signed({1'b0, wx5_r});
  assign sx1 = $signed({1'b0, WT_W'(1 << FRAC_BITS)}) - sx;
  logic signed [H0_W-1:0] h0_r, h1_r;
  logic v6_r, f6_r;
  logic [WT_W-1:0] wy6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
    f6_r <= f5_r; wy6_r <= wy5_r;
    h0_r <= $signed(h00) * sx1 + $signed(h01) * sx;
    h1_r <= $signed(h10) * sx1 + $signed(h11) * sx;
  end

  // stage 7: vertical blend and round
  assign sy  = $signed({1'b0, wy6_r});
  assign sy1 = $signed({1'b0, WT_W'(1 << FRAC_BITS)}) - sy;
  logic signed [H_W-1:0] h;
  assign h = h0_r * sy1 + h1_r * sy + H_W'(64'sd1 <<< (SH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v6_r;
    out_found     <= f6_r;
    out_elevation <= f6_r ? 24'(h >>> SH) : '0;
  end
endmodule
`default_nettype wire

### hw/rtl/dtbe_checker.sv
// ----------------------------------------------------------------------------
// dtbe_checker
// port level checks for the terrain elevation block
// ----------------------------------------------------------------------------
`default_nettype none
module dtbe_checker
  import dtbe_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_action,
  input wire logic       out_valid,
  input wire logic [23:0] out_elevation,
  input wire logic       out_found
);
  logic q;
  assign q = start && !busy && in_action == ACT_QUERY;

  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q, 7)) else $error("result without query");
  a_q: assert property (@(posedge clk) disable iff (!rst_n)
    q |-> ##7 out_valid) else $error("query lost");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_elevation == '0) else $error("miss nonzero");
endmodule

bind dem_tile_bilinear_elevation_top dtbe_checker u_dtbe_checker (
  .clk, .rst_n, .start, .busy, .in_action, .out_valid, .out_elevation, .out_found);
`default_nettype wire
